FILE: rtl/core/taob_pkg.sv
// ---------------------------------------------------------------------------
// taob_pkg
// Shared types, constants and elaboration-time table builders for the
// touch-driven additive oscillator bank.
// ---------------------------------------------------------------------------
package taob_pkg;

    // Port field widths
    localparam int PIN_W      = 4;
    localparam int COUNT_W    = 10;
    localparam int SAMPLE_W   = 19;
    localparam int THRESH_W   = 10;
    localparam int INTERVAL_W = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_TOUCH_THRESHOLD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_READ_INTERVAL   = 1'd1;

    localparam logic [THRESH_W-1:0]   TOUCH_THRESHOLD_RST = 10'd40;
    localparam logic [INTERVAL_W-1:0] READ_INTERVAL_RST   = 16'd882;

    // Defaults for top-level parameters
    localparam int DEF_NUM_PINS        = 12;
    localparam int DEF_SINE_TABLE_BITS = 10;
    localparam int DEF_SAMPLE_RATE     = 44100;

    // Level and datapath widths
    localparam int LEVEL_W   = 8;
    localparam int LEVEL_MAX = 200;
    localparam int DELTA_W   = 12;
    localparam int PHASE_W   = 32;
    localparam int SINE_W    = 16;
    localparam int PROD_W    = 25;   // 9-bit level times Q1.15
    localparam int ACC_W     = 28;   // up to 16 pins * 200 * 32767

    // Floor divide by 400: arithmetic shift by 4, bias, reciprocal of 25
    localparam int DIV_SHIFT   = 4;
    localparam int DIV_U_W     = 25;
    localparam int DIV_BIAS_EXP = 19;
    localparam logic [DIV_U_W-1:0] DIV_BIAS = DIV_U_W'(25 * (1 << DIV_BIAS_EXP));
    localparam int RECIP_W     = 26;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd25);
    localparam int DIVPROD_W   = DIV_U_W + RECIP_W;
    localparam int Q_W         = DIVPROD_W - RECIP_SHIFT;
    localparam int REM_W       = 26;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;

    // Scale pitches in 0.01 Hz
    localparam int SCALE_LEN = 12;
    localparam int unsigned PITCH_CENTIHZ [SCALE_LEN] = '{
        26163, 29366, 32963, 34923, 39200, 44000,
        49388, 52325, 58733, 65925, 69825, 78399
    };

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Work item passed from front to back
    typedef struct packed {
        logic               is_tick;
        logic [PIN_W-1:0]   pin;
        logic [LEVEL_W-1:0] level;
        logic               read_request;
    } t_job;

    // sin(2*pi*q/2^bits) in Q15 for a quarter wave; Q30 Taylor series, 8 terms
    function automatic logic [SINE_W-1:0] quarter_sine(int unsigned q, int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        int                 n;
        x    = (64'(q) * 64'd2 * PI_Q30) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (n = 1; n < 8; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                default: term = term / 64'd210;
            endcase
            if ((n & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = ((64'(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return SINE_W'(v);
    endfunction

    // Full-wave table entry from quarter-wave symmetry
    function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned k, int unsigned bits);
        int unsigned        len;
        int unsigned        half;
        int unsigned        quarter;
        logic signed [SINE_W-1:0] s;
        len     = 1 << bits;
        half    = len >> 1;
        quarter = len >> 2;
        if (k <= quarter) begin
            s = $signed(quarter_sine(k, bits));
        end else if (k < half) begin
            s = $signed(quarter_sine(half - k, bits));
        end else if (k <= half + quarter) begin
            s = -$signed(quarter_sine(k - half, bits));
        end else begin
            s = -$signed(quarter_sine(len - k, bits));
        end
        return s;
    endfunction

endpackage

FILE: rtl/core/taob_queue.sv
// ---------------------------------------------------------------------------
// taob_queue
// Small FIFO of jobs between the front and back parts.
// ---------------------------------------------------------------------------
module taob_queue
    import taob_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_en,
    input  t_job i_wr_job,
    output logic o_full,
    input  logic i_rd_en,
    output logic o_rd_valid,
    output t_job o_rd_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             w_wr, w_rd;

    assign w_wr = i_wr_en && (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_rd = i_rd_en && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    assign o_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_job   = r_mem[r_rd_ptr];

endmodule

FILE: rtl/core/taob_front.sv
// ---------------------------------------------------------------------------
// taob_front
// Accepts items, holds config, turns sensor readings into levels and runs
// the read-request tick counter.
// ---------------------------------------------------------------------------
module taob_front
    import taob_pkg::*;
#(
    parameter int NUM_PINS = DEF_NUM_PINS
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_kind,
    input  logic [PIN_W-1:0]      i_pin,
    input  logic [COUNT_W-1:0]    i_filtered_count,
    input  logic [COUNT_W-1:0]    i_baseline_count,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    output logic                  o_enq,
    output t_job                  o_job
);

    logic [THRESH_W-1:0]   r_threshold;
    logic [INTERVAL_W-1:0] r_interval;
    logic [INTERVAL_W-1:0] r_tick_count, n_tick_count;
    logic [INTERVAL_W:0]   w_count_inc;
    logic                  w_req;
    logic signed [DELTA_W-1:0] w_delta;
    logic [LEVEL_W-1:0]    w_level;
    logic                  w_pin_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= TOUCH_THRESHOLD_RST;
            r_interval  <= READ_INTERVAL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_TOUCH_THRESHOLD: r_threshold <= i_cfg_wdata[THRESH_W-1:0];
                CFG_READ_INTERVAL:   r_interval  <= i_cfg_wdata[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // count + 1 kept one bit wider so the compare cannot wrap
    assign w_count_inc = {1'b0, r_tick_count} + 1'b1;
    assign w_req       = (w_count_inc >= {1'b0, r_interval});

    always_comb begin
        n_tick_count = r_tick_count;
        if (i_accept && !i_kind) begin
            n_tick_count = w_req ? '0 : w_count_inc[INTERVAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
        end else begin
            r_tick_count <= n_tick_count;
        end
    end

    // level = clamp(baseline - filtered - threshold, 0, 200)
    assign w_delta = $signed({2'b00, i_baseline_count})
                   - $signed({2'b00, i_filtered_count})
                   - $signed({2'b00, r_threshold});

    always_comb begin
        if (w_delta < 0) begin
            w_level = '0;
        end else if (w_delta > DELTA_W'(LEVEL_MAX)) begin
            w_level = LEVEL_W'(LEVEL_MAX);
        end else begin
            w_level = w_delta[LEVEL_W-1:0];
        end
    end

    assign w_pin_ok = ({1'b0, i_pin} < (PIN_W + 1)'(NUM_PINS));

    // out-of-range sensor items are dropped here
    assign o_enq              = i_accept && (!i_kind || w_pin_ok);
    assign o_job.is_tick      = !i_kind;
    assign o_job.pin          = i_pin;
    assign o_job.level        = w_level;
    assign o_job.read_request = w_req;

endmodule

FILE: rtl/core/taob_back.sv
// ---------------------------------------------------------------------------
// taob_back
// Oscillator state, sine ROM, shared multiply-accumulate over the pins,
// floor divide by 400 and the result register.
// ---------------------------------------------------------------------------
module taob_back
    import taob_pkg::*;
#(
    parameter int NUM_PINS        = DEF_NUM_PINS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
    parameter int SAMPLE_RATE     = DEF_SAMPLE_RATE
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  t_job                       i_job,
    output logic                       o_job_take,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_read_request
);

    localparam int SINE_LEN  = 1 << SINE_TABLE_BITS;
    localparam int PIN_IDX_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_DIV0  = 3'd3;
    localparam logic [2:0] S_DIV1  = 3'd4;
    localparam logic [2:0] S_DIV2  = 3'd5;

    logic [2:0]                  r_state;
    logic [PIN_IDX_W-1:0]        r_pin;
    logic                        r_req;
    logic [LEVEL_W-1:0]          r_level [NUM_PINS];
    logic [PHASE_W-1:0]          r_phase [NUM_PINS];
    logic [PHASE_W-1:0]          w_inc   [NUM_PINS];
    logic signed [SINE_W-1:0]    w_sine_rom [SINE_LEN];

    logic                        r_v1, r_v2, r_v3;
    logic [SINE_TABLE_BITS-1:0]  r_idx1;
    logic [LEVEL_W-1:0]          r_lvl1, r_lvl2;
    logic signed [SINE_W-1:0]    r_sine;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;

    logic [DIV_U_W-1:0]          r_u;
    logic [DIVPROD_W-1:0]        r_divprod;
    logic [Q_W-1:0]              w_q0, w_q;
    logic [REM_W-1:0]            w_rem;
    logic [Q_W-1:0]              w_sample_ext;

    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic                        r_out_req;
    logic                        w_out_free;
    logic                        w_last_pin;

    // Phase increments: round(f * 2^32 / rate), octave up per twelve pins
    for (genvar p = 0; p < NUM_PINS; p++) begin : g_inc
        localparam logic [63:0] F   = 64'(PITCH_CENTIHZ[p % SCALE_LEN]) << (p / SCALE_LEN);
        localparam logic [63:0] DEN = 64'(SAMPLE_RATE) * 64'd100;
        localparam logic [PHASE_W-1:0] INC = PHASE_W'(((F << 32) + DEN / 2) / DEN);
        assign w_inc[p] = INC;
    end

    for (genvar k = 0; k < SINE_LEN; k++) begin : g_rom
        assign w_sine_rom[k] = sine_entry(k, SINE_TABLE_BITS);
    end

    assign w_last_pin = (r_pin == PIN_IDX_W'(NUM_PINS - 1));
    assign w_out_free = !r_out_valid || i_pop;
    assign o_job_take = (r_state == S_IDLE) && i_job_valid;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pin   <= '0;
            r_req   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid && i_job.is_tick) begin
                        r_pin   <= '0;
                        r_req   <= i_job.read_request;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_last_pin) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_pin <= r_pin + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // last product lands in the accumulator this cycle
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_DIV0;
                    end
                end
                S_DIV0:  r_state <= S_DIV1;
                S_DIV1:  r_state <= S_DIV2;
                S_DIV2: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Pin levels and phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PINS; i++) begin
                r_level[i] <= '0;
                r_phase[i] <= '0;
            end
        end else begin
            if (o_job_take && !i_job.is_tick) begin
                r_level[i_job.pin[PIN_IDX_W-1:0]] <= i_job.level;
            end
            if (r_state == S_RUN) begin
                r_phase[r_pin] <= r_phase[r_pin] + w_inc[r_pin];
            end
        end
    end

    // MAC pipeline: phase/level read, ROM read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_RUN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_phase[r_pin][PHASE_W-1 -: SINE_TABLE_BITS];
        r_lvl1 <= r_level[r_pin];
        r_sine <= w_sine_rom[r_idx1];
        r_lvl2 <= r_lvl1;
        r_prod <= PROD_W'($signed({1'b0, r_lvl2})) * PROD_W'(r_sine);
        if (o_job_take && i_job.is_tick) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // floor(acc / 400) = floor(floor(acc / 16) / 25), biased positive
    always_ff @(posedge i_clk) begin
        r_u       <= DIV_U_W'(r_acc >>> DIV_SHIFT) + DIV_BIAS;
        r_divprod <= DIVPROD_W'(r_u) * DIVPROD_W'(RECIP_M);
    end

    assign w_q0  = r_divprod[DIVPROD_W-1:RECIP_SHIFT];
    assign w_rem = REM_W'(r_u) - REM_W'(REM_W'(w_q0) * REM_W'(25));
    assign w_q   = (w_rem >= REM_W'(25)) ? w_q0 + 1'b1 : w_q0;
    assign w_sample_ext = w_q - Q_W'(1 << DIV_BIAS_EXP);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DIV2) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV2) && w_out_free) begin
            r_sample  <= $signed(w_sample_ext[SAMPLE_W-1:0]);
            r_out_req <= r_req;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_sample_out   = r_sample;
    assign o_read_request = r_out_req;

endmodule

FILE: rtl/core/touch_driven_additive_oscillator_bank.sv
// ---------------------------------------------------------------------------
// touch_driven_additive_oscillator_bank
// Bank of sine oscillators at fixed scale pitches, loudness per touch pin.
// ---------------------------------------------------------------------------
// Items come in through a push/full queue port and come out through an
// empty/pop port. A sensor item (kind = 1) sets one pin's level to
// clamp(baseline - filtered - touch_threshold, 0, 200) and gives no result;
// a pin index at or above NUM_PINS is dropped. A tick item (kind = 0) gives
// exactly one result: the Q.15 sum of level * sine over all pins, floored
// divide by 400, plus read_request, raised every read_interval_ticks ticks.
// The front accepts one item per cycle, unless the four-entry job queue is
// full, so it keeps taking items while the back is busy or a result waits to
// be popped. In the back a sensor item only sets its pin's level; for a tick
// one shared multiply-accumulate visits the pins one per cycle, then a
// three-stage floor divide by 400 finishes it.
// Config writes (0: touch_threshold, 1: read_interval_ticks) take effect at
// once and are meant to be done while the block is idle.
// ---------------------------------------------------------------------------
module touch_driven_additive_oscillator_bank
    import taob_pkg::*;
#(
    parameter int NUM_PINS        = DEF_NUM_PINS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
    parameter int SAMPLE_RATE     = DEF_SAMPLE_RATE
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item input
    input  logic                       push,
    output logic                       full,
    input  logic                       i_kind,
    input  logic [PIN_W-1:0]           i_pin,
    input  logic [COUNT_W-1:0]         i_filtered_count,
    input  logic [COUNT_W-1:0]         i_baseline_count,
    // result output
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic                       o_read_request,
    // config writes
    input  logic                       i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [CFG_W-1:0]           i_cfg_wdata
);

    logic w_accept;
    logic w_enq;
    t_job w_enq_job;
    logic w_job_valid;
    t_job w_job;
    logic w_job_take;

    // item accepted at this edge
    assign w_accept = push && !full;

    // Front: config, level calc, tick counter
    taob_front #(
        .NUM_PINS (NUM_PINS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_kind           (i_kind),
        .i_pin            (i_pin),
        .i_filtered_count (i_filtered_count),
        .i_baseline_count (i_baseline_count),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_enq            (w_enq),
        .o_job            (w_enq_job)
    );

    // Jobs in order; full backs up the input port
    taob_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_enq),
        .i_wr_job   (w_enq_job),
        .o_full     (full),
        .i_rd_en    (w_job_take),
        .o_rd_valid (w_job_valid),
        .o_rd_job   (w_job)
    );

    // Back: oscillators, MAC, divide, result register
    taob_back #(
        .NUM_PINS        (NUM_PINS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_RATE     (SAMPLE_RATE)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_job_valid),
        .i_job          (w_job),
        .o_job_take     (w_job_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_sample_out   (o_sample_out),
        .o_read_request (o_read_request)
    );

endmodule

FILE: rtl/core/taob_checker.sv
// ---------------------------------------------------------------------------
// taob_checker
// Port-level checks for the oscillator bank, bound to the top level.
// ---------------------------------------------------------------------------
module taob_checker
    import taob_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic signed [SAMPLE_W-1:0] o_sample_out,
    input logic                       o_read_request
);

    // reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // reset leaves the job queue open
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked right after reset");

    // waiting result holds until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_sample_out) && $stable(o_read_request)))
        else $error("waiting result changed or vanished");

    // twelve full-level pins bound the sample to +/- 6 * 32768
    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_sample_out >= -19'sd196608) && (o_sample_out <= 19'sd196608))
        else $error("sample out of range");

endmodule

bind touch_driven_additive_oscillator_bank taob_checker u_taob_checker (.*);
